// File: hw/rtl/hsc_pkg.sv
package hsc_pkg;

  localparam int OBJ_W   = 9;
  localparam int WORD_W  = 64;
  localparam int IDX_W   = 14;
  localparam int PROBE_W = 7;

  localparam logic [WORD_W-1:0] HASH_MUL_OBJ = 64'h9E37_79B9_7F4A_7C15;
  localparam logic [WORD_W-1:0] HASH_MUL_OFF = 64'hC2B2_AE3D_27D4_EB4F;
  localparam int                HASH_FOLD    = 29;

  localparam logic [PROBE_W-1:0] PROBE_RESET = 7'd64;

  // command codes
  localparam logic CMD_COUNT = 1'b0;
  localparam logic CMD_READ  = 1'b1;

  // outcome codes
  localparam logic [1:0] OUT_NEW  = 2'd0;
  localparam logic [1:0] OUT_INC  = 2'd1;
  localparam logic [1:0] OUT_DROP = 2'd2;
  localparam logic [1:0] OUT_READ = 2'd3;

  // register word index (paddr[2])
  localparam logic REG_PROBE_LIMIT = 1'b0;

  typedef struct packed {
    logic [OBJ_W-1:0]  obj;
    logic [WORD_W-1:0] off;
    logic [WORD_W-1:0] cnt;
  } entry_t;

  typedef struct packed {
    logic rd;
    logic wr;
  } tbl_cmd_t;

endpackage

// File: hw/rtl/hsc_hash.sv
module hsc_hash (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [hsc_pkg::OBJ_W-1:0] obj,
  input  logic [hsc_pkg::WORD_W-1:0] off,
  output logic                      done,
  output logic [hsc_pkg::WORD_W-1:0] home_hash
);
  import hsc_pkg::*;

  // one 32x32 multiplier, five partial products, each accumulated from the registered product of the step before
  localparam logic [2:0] ST_OBJ_LO = 3'd0;
  localparam logic [2:0] ST_OBJ_HI = 3'd1;
  localparam logic [2:0] ST_OFF_LL = 3'd2;
  localparam logic [2:0] ST_OFF_LH = 3'd3;
  localparam logic [2:0] ST_OFF_HL = 3'd4;
  localparam logic [2:0] ST_LAST   = 3'd5;

  logic              busy;
  logic [2:0]        step;
  logic [OBJ_W-1:0]  q_obj;
  logic [WORD_W-1:0] q_off;
  logic [31:0]       op_a;
  logic [31:0]       op_b;
  logic [63:0]       prod;
  logic [WORD_W-1:0] acc_obj;
  logic [WORD_W-1:0] acc_off;
  logic [WORD_W-1:0] hsum;

  always_comb begin
    case (step)
      ST_OBJ_LO: begin
        op_a = 32'(q_obj);
        op_b = HASH_MUL_OBJ[31:0];
      end
      ST_OBJ_HI: begin
        op_a = 32'(q_obj);
        op_b = HASH_MUL_OBJ[63:32];
      end
      ST_OFF_LL: begin
        op_a = q_off[31:0];
        op_b = HASH_MUL_OFF[31:0];
      end
      ST_OFF_LH: begin
        op_a = q_off[31:0];
        op_b = HASH_MUL_OFF[63:32];
      end
      ST_OFF_HL: begin
        op_a = q_off[63:32];
        op_b = HASH_MUL_OFF[31:0];
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= ST_OBJ_LO;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= ST_OBJ_LO;
      end else if (busy) begin
        step <= step + 3'd1;
        if (step == ST_LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_obj   <= obj;
      q_off   <= off;
      acc_obj <= '0;
      acc_off <= '0;
    end else if (busy) begin
      prod <= op_a * op_b;
      // prod holds the product issued in the previous step
      case (step) inside
        ST_OBJ_HI:          acc_obj <= acc_obj + prod;
        ST_OFF_LL:          acc_obj <= acc_obj + {prod[31:0], 32'b0};
        ST_OFF_LH:          acc_off <= acc_off + prod;
        ST_OFF_HL, ST_LAST: acc_off <= acc_off + {prod[31:0], 32'b0};
        default:            acc_obj <= acc_obj;
      endcase
    end
  end

  assign hsum      = acc_obj ^ acc_off;
  assign home_hash = hsum ^ (hsum >> HASH_FOLD);

endmodule

// File: hw/rtl/hsc_table.sv
module hsc_table #(
  parameter int DEPTH = 16384
) (
  input  logic                         clk,
  input  logic                         rst,
  input  hsc_pkg::tbl_cmd_t            tcmd,
  input  logic [$clog2(DEPTH)-1:0]     addr,
  input  hsc_pkg::entry_t              wr_data,
  output logic                         rd_valid,
  output hsc_pkg::entry_t              rd_data,
  output logic                         busy
);
  import hsc_pkg::*;

  localparam int AW = $clog2(DEPTH);

  logic           valid_mem [DEPTH];
  entry_t         ent_mem   [DEPTH];
  logic [AW-1:0]  clr_addr;

  // valid marks are swept to zero after reset, one slot per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b1;
      clr_addr <= '0;
    end else if (busy) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == AW'(DEPTH - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy) begin
      valid_mem[clr_addr] <= 1'b0;
    end else if (tcmd.wr) begin
      valid_mem[addr] <= 1'b1;
    end
    if (tcmd.rd) begin
      rd_valid <= valid_mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (tcmd.wr) begin
      ent_mem[addr] <= wr_data;
    end
    if (tcmd.rd) begin
      rd_data <= ent_mem[addr];
    end
  end

endmodule

// File: hw/rtl/hashed_sample_counter.sv
// channel  | handshake              | payload
// ---------+------------------------+------------------------------------------
// apb      | psel/penable, pready=1 | paddr, pwdata, prdata (probe_limit)
// in       | in_valid / in_ready    | cmd, object_id, offset, read_index
// out      | out_valid / out_ready  | outcome, slot_index, entry_*, dropped_total
//
// Count item: accepted, hashed (five partial products on one 32x32 multiplier),
//   then per probe a table read and a compare/write, then loaded into the output register.
// Read item: reads the slot at read_index. A sample drops once probe_limit probes hit other keys.
// After reset the valid marks of all TABLE_DEPTH slots are swept; in_ready is low.
// The finished result waits in the output register; the next item is taken
// meanwhile, and its result stalls only if the output is still occupied.
module hashed_sample_counter #(
  parameter int TABLE_DEPTH = 16384
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [2:0]                  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        cmd,
  input  logic [hsc_pkg::OBJ_W-1:0]   object_id,
  input  logic [hsc_pkg::WORD_W-1:0]  offset,
  input  logic [hsc_pkg::IDX_W-1:0]   read_index,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [1:0]                  outcome,
  output logic [hsc_pkg::IDX_W-1:0]   slot_index,
  output logic                        entry_valid,
  output logic [hsc_pkg::OBJ_W-1:0]   entry_object,
  output logic [hsc_pkg::WORD_W-1:0]  entry_offset,
  output logic [hsc_pkg::WORD_W-1:0]  entry_count,
  output logic [hsc_pkg::WORD_W-1:0]  dropped_total
);
  import hsc_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);

  typedef enum logic [6:0] {
    S_IDLE    = 7'b0000001,
    S_HASH    = 7'b0000010,
    S_PROBE   = 7'b0000100,
    S_CHECK   = 7'b0001000,
    S_READ    = 7'b0010000,
    S_READCHK = 7'b0100000,
    S_EMIT    = 7'b1000000
  } state_t;

  state_t             state;
  logic [PROBE_W-1:0] probe_limit;
  logic [PROBE_W-1:0] pcount;
  logic [WORD_W-1:0]  dropped_count;

  logic [OBJ_W-1:0]   q_obj;
  logic [WORD_W-1:0]  q_off;
  logic [AW-1:0]      slot;

  logic [1:0]         res_outcome;
  logic [AW-1:0]      res_slot;
  logic               res_valid;
  logic [OBJ_W-1:0]   res_obj;
  logic [WORD_W-1:0]  res_off;
  logic [WORD_W-1:0]  res_cnt;

  logic               accept;
  logic               hash_start;
  logic               hash_done;
  logic [WORD_W-1:0]  hash_home;
  tbl_cmd_t           tcmd;
  entry_t             wr_data;
  entry_t             rd_data;
  logic               rd_valid;
  logic               tbl_busy;
  logic               hit;
  logic               limit_hit;
  logic               out_free;
  logic               cfg_wr;

  assign pready     = 1'b1;
  assign cfg_wr     = psel && penable && pwrite && pready;
  assign prdata     = (paddr[2] == REG_PROBE_LIMIT) ? 32'(probe_limit) : '0;

  assign in_ready   = (state == S_IDLE) && !tbl_busy;
  assign accept     = in_valid && in_ready;
  assign hash_start = accept && (cmd == CMD_COUNT);
  assign out_free   = !out_valid || out_ready;

  assign hit        = (rd_data.obj == q_obj) && (rd_data.off == q_off);
  assign limit_hit  = (pcount == probe_limit);

  assign tcmd.rd    = ((state == S_PROBE) && !limit_hit) || (state == S_READ);
  assign tcmd.wr    = (state == S_CHECK) && (!rd_valid || hit);
  assign wr_data.obj = q_obj;
  assign wr_data.off = q_off;
  assign wr_data.cnt = rd_valid ? rd_data.cnt + 64'd1 : 64'd1;

  hsc_hash u_hash (
    .clk       (clk),
    .rst       (rst),
    .start     (hash_start),
    .obj       (object_id),
    .off       (offset),
    .done      (hash_done),
    .home_hash (hash_home)
  );

  hsc_table #(
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk      (clk),
    .rst      (rst),
    .tcmd     (tcmd),
    .addr     (slot),
    .wr_data  (wr_data),
    .rd_valid (rd_valid),
    .rd_data  (rd_data),
    .busy     (tbl_busy)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      probe_limit   <= PROBE_RESET;
      pcount        <= '0;
      dropped_count <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_wr && (paddr[2] == REG_PROBE_LIMIT)) begin
        probe_limit <= pwdata[PROBE_W-1:0];
      end
      if ((state == S_EMIT) && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            state <= (cmd == CMD_READ) ? S_READ : S_HASH;
          end
        end
        S_HASH: begin
          if (hash_done) begin
            pcount <= '0;
            state  <= S_PROBE;
          end
        end
        S_PROBE: begin
          if (limit_hit) begin
            dropped_count <= dropped_count + 64'd1;
            state         <= S_EMIT;
          end else begin
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (rd_valid && !hit) begin
            pcount <= pcount + 1'b1;
            state  <= S_PROBE;
          end else begin
            state <= S_EMIT;
          end
        end
        S_READ:    state <= S_READCHK;
        S_READCHK: state <= S_EMIT;
        S_EMIT: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      q_obj <= object_id;
      q_off <= offset;
      if (cmd == CMD_READ) begin
        slot <= AW'(read_index);
      end
    end
    if ((state == S_HASH) && hash_done) begin
      slot <= hash_home[AW-1:0];
    end
    if ((state == S_PROBE) && limit_hit) begin
      res_outcome <= OUT_DROP;
      res_slot    <= '0;
      res_valid   <= 1'b0;
      res_obj     <= '0;
      res_off     <= '0;
      res_cnt     <= '0;
    end
    if (state == S_CHECK) begin
      if (!rd_valid || hit) begin
        res_outcome <= rd_valid ? OUT_INC : OUT_NEW;
        res_slot    <= slot;
        res_valid   <= 1'b1;
        res_obj     <= q_obj;
        res_off     <= q_off;
        res_cnt     <= wr_data.cnt;
      end else begin
        slot <= slot + 1'b1;
      end
    end
    if (state == S_READCHK) begin
      // an empty slot reports zeros, whatever the store holds
      res_outcome <= OUT_READ;
      res_slot    <= slot;
      res_valid   <= rd_valid;
      res_obj     <= rd_valid ? rd_data.obj : '0;
      res_off     <= rd_valid ? rd_data.off : '0;
      res_cnt     <= rd_valid ? rd_data.cnt : '0;
    end
    if ((state == S_EMIT) && out_free) begin
      outcome       <= res_outcome;
      slot_index    <= IDX_W'(res_slot);
      entry_valid   <= res_valid;
      entry_object  <= res_obj;
      entry_offset  <= res_off;
      entry_count   <= res_cnt;
      dropped_total <= dropped_count;
    end
  end

  a_drop_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (outcome == OUT_DROP)) |-> (!entry_valid && (slot_index == '0)
      && (entry_count == '0)))
    else $error("dropped result carries slot data");

  a_new_count_one: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (outcome == OUT_NEW)) |-> (entry_valid && (entry_count == 64'd1)))
    else $error("new entry without count one");

  a_probe_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_CHECK) |-> (pcount < probe_limit))
    else $error("probe beyond limit");

  a_drop_step: assert property (@(posedge clk) disable iff (rst)
    ((state == S_PROBE) && limit_hit) |=> (dropped_count == $past(dropped_count) + 64'd1))
    else $error("dropped counter not advanced");

endmodule
